[hw/rtl/skst_pkg.sv]
// sorted key set table: shared constants, transaction payload types,
// controller states and the command and status bundles
// no dependencies
package skst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_NULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES,
    S_UPD
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] position;
    logic [8:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    cmp;
    logic    res;
    logic    upd_ins;
    logic    upd_rem;
    logic    pos_keep;
    logic    out_load;
    status_t status;
  } ctl_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       full;
    logic       null_key;
    logic [1:0] opcode;
  } dp_stat_t;

endpackage

[hw/rtl/skst_dp.sv]
// sorted key set table datapath: row of key cells with per-cell compare,
// boundary encoder and parallel shift for insert and remove
// depends on skst_pkg
module skst_dp import skst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output out_item_t res_item
);

  logic [KEY_BITS-1:0]    cells_r [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    cells_nxt [TABLE_DEPTH];
  wire  [KEY_BITS-1:0]    below_w [TABLE_DEPTH];
  wire  [KEY_BITS-1:0]    above_w [TABLE_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [KEY_BITS-1:0]    key_r;
  logic [1:0]             op_r;
  logic [TABLE_DEPTH-1:0] valid_w, lt_nxt, eq_nxt, lt_r, eq_r, bnd_w;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic                   hit_r;

  // per-cell compare against the held key
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid_w[i] = CNT_W'(i) < count_r;
      lt_nxt[i]  = valid_w[i] && (cells_r[i] < key_r);
      eq_nxt[i]  = valid_w[i] && (cells_r[i] == key_r);
    end
  end

  // first cell not below the key
  assign bnd_w = ~lt_r & {lt_r[TABLE_DEPTH-2:0], 1'b1};

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pos_nxt = pos_nxt | (bnd_w[i] ? IDX_W'(i) : '0);
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign below_w[g] = key_r;
    end else begin : g_mid
      assign below_w[g] = lt_r[g-1] ? key_r : cells_r[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign above_w[g] = cells_r[g];
    end else begin : g_upper
      assign above_w[g] = cells_r[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.upd_ins && !lt_r[i]) begin
        cells_nxt[i] = below_w[i];
      end else if (cmd.upd_rem && !lt_r[i]) begin
        cells_nxt[i] = above_w[i];
      end else begin
        cells_nxt[i] = cells_r[i];
      end
    end
  end

  always_comb begin
    if (cmd.upd_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.upd_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.load) begin
      key_r <= KEY_BITS'(in_data.key);
      op_r  <= in_data.opcode;
    end
    if (cmd.cmp) begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
    if (cmd.res) begin
      hit_r <= |eq_r;
      pos_r <= pos_nxt;
    end
  end

  assign stat.hit      = hit_r;
  assign stat.full     = count_r == CNT_W'(TABLE_DEPTH);
  assign stat.null_key = key_r == '0;
  assign stat.opcode   = op_r;

  assign res_item.status      = cmd.status;
  assign res_item.position    = cmd.pos_keep ? 8'(pos_r) : '0;
  assign res_item.entry_count = 9'(count_nxt);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the set");

  a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_rem |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not shrink the set");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |-> ((lt_r >> 1) & ~lt_r) == '0)
    else $error("cells out of order");

endmodule

[hw/rtl/skst_ctrl.sv]
// sorted key set table controller: sequences load, compare, resolve and
// update, and decides the result status
// depends on skst_pkg
module skst_ctrl import skst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.status = ST_NOT_FOUND;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        cmd.res   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          if (stat.null_key) begin
            cmd.status = ST_NULL;
          end else begin
            case (stat.opcode)
              OP_INSERT: begin
                if (stat.hit) begin
                  cmd.status = ST_PRESENT;
                end else if (stat.full) begin
                  cmd.status = ST_FULL;
                end else begin
                  cmd.status   = ST_INSERTED;
                  cmd.upd_ins  = 1'b1;
                  cmd.pos_keep = 1'b1;
                end
              end
              OP_REMOVE: begin
                if (stat.hit) begin
                  cmd.status   = ST_REMOVED;
                  cmd.upd_rem  = 1'b1;
                  cmd.pos_keep = 1'b1;
                end
              end
              default: begin
                if (stat.hit) begin
                  cmd.status   = ST_FOUND;
                  cmd.pos_keep = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.upd_ins && cmd.upd_rem))
    else $error("insert and remove in one cycle");

  a_update_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_ins || cmd.upd_rem) |-> cmd.out_load)
    else $error("store changed without a result");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_CMP)
    else $error("accepted transaction not compared");

endmodule

[hw/rtl/sorted_key_set_table.sv]
// Sorted set of up to 256 distinct nonzero 32-bit keys, held in ascending
// order in a row of key registers. Each transaction is a find, an insert or a
// remove and gives exactly one result. The controller steps through accept,
// compare every cell, resolve hit and position, and update; the result is
// loaded into the result register in the update step, and a new transaction
// is accepted only after that; update waits while an earlier result is still
// held in the result register. No clearing pass after reset.
module sorted_key_set_table import skst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  out_item_t res_item;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      out_free;

  assign out_free = !out_valid_r || out_ready;

  skst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  skst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .res_item (res_item)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/skst_result_checker.sv]
// sorted key set table checker: keeps its own copy of the key store, works out
// the answer to every accepted request and compares it with the block's answer
// depends on skst_pkg
module skst_result_checker import skst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        answers_left,
  output int        answers_checked,
  output int        full_refusals
);

  logic [KEY_BITS-1:0] held_keys [TABLE_DEPTH];
  int unsigned         held_count;
  out_item_t           answers_due [$];

  function automatic int unsigned first_not_below(logic [KEY_BITS-1:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < k) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // updates the store copy and returns the answer the block should give
  function automatic out_item_t apply_request(in_item_t req);
    logic [KEY_BITS-1:0] k;
    int unsigned         slot;
    int unsigned         i;
    logic                hit;
    out_item_t           ans;
    k            = req.key[KEY_BITS-1:0];
    ans.status   = ST_NOT_FOUND;
    ans.position = '0;
    if (k == '0) begin
      ans.status = ST_NULL;
    end else begin
      slot = first_not_below(k);
      hit  = (slot < held_count) && (held_keys[slot] == k);
      case (req.opcode)
        OP_INSERT: begin
          if (hit) begin
            ans.status = ST_PRESENT;
          end else if (held_count >= TABLE_DEPTH) begin
            ans.status = ST_FULL;
          end else begin
            for (i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
            held_keys[slot] = k;
            held_count++;
            ans.status   = ST_INSERTED;
            ans.position = slot[7:0];
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
            held_count--;
            ans.status   = ST_REMOVED;
            ans.position = slot[7:0];
          end
        end
        default: begin
          if (hit) begin
            ans.status   = ST_FOUND;
            ans.position = slot[7:0];
          end
        end
      endcase
    end
    ans.entry_count = held_count[8:0];
    return ans;
  endfunction

  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      held_count = 0;
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: answer with none expected, status %0d position %0d count %0d",
                   $time, out_data.status, out_data.position, out_data.entry_count);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          answers_checked++;
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %s got %0d",
                     $time, want.status.name(), out_data.status);
            fail_count++;
          end
          if (out_data.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d got %0d",
                     $time, want.position, out_data.position);
            fail_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $display("%0t: entry count mismatch, expected %0d got %0d",
                     $time, want.entry_count, out_data.entry_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(in_data);
        if (want.status == ST_FULL) full_refusals++;
        answers_due.push_back(want);
      end
    end
    answers_left = answers_due.size();
  end

endmodule

[sim/tb.sv]
// sorted key set table testbench: clock, reset, request stimulus and verdict
// depends on skst_pkg, sorted_key_set_table and skst_result_checker
module tb;
  import skst_pkg::*;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam int         POOL_SIZE = 384;

  typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} traffic_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int          fail_count;
  int          answers_left;
  int          answers_checked;
  int          full_refusals;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          requests_sent;
  int          settle;
  int unsigned pool_cursor;
  logic [31:0] key_pool [POOL_SIZE];

  sorted_key_set_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  skst_result_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .answers_left    (answers_left),
    .answers_checked (answers_checked),
    .full_refusals   (full_refusals)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t: run did not finish in time", $time);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic push_request(input logic [1:0] op, input logic [31:0] k);
    in_item_t req;
    req.opcode = op;
    req.key    = k;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    requests_sent++;
  endtask

  // walking keys go through the pool in order so the store fills and empties
  function automatic logic [31:0] pick_key(logic walk);
    int unsigned roll;
    logic [31:0] k;
    roll = $urandom_range(99);
    if (roll < 3) begin
      k = '0;
    end else if (roll < 8) begin
      k = $urandom;
    end else if (walk) begin
      k = key_pool[pool_cursor % POOL_SIZE];
      pool_cursor++;
    end else begin
      k = key_pool[$urandom_range(POOL_SIZE-1)];
    end
    return k;
  endfunction

  task automatic push_random(input traffic_t shape);
    int unsigned roll;
    logic [1:0]  op;
    logic        walk;
    roll = $urandom_range(99);
    case (shape)
      FILL_UP:    op = (roll < 90) ? OP_INSERT : (roll < 97) ? OP_LOOKUP : OP_SPARE;
      DRAIN_DOWN: op = (roll < 88) ? OP_REMOVE : (roll < 96) ? OP_LOOKUP : OP_INSERT;
      default: begin
        op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
             (roll < 95) ? OP_LOOKUP : OP_SPARE;
      end
    endcase
    walk = (shape == FILL_UP && op == OP_INSERT) || (shape == DRAIN_DOWN && op == OP_REMOVE);
    push_request(op, pick_key(walk));
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    snd_idle_pct  <= 26;
    rcv_idle_pct  <= 57;
    requests_sent = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'd1;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, null keys on every opcode, extreme keys, hits and misses
    push_request(OP_LOOKUP, 32'd5);
    push_request(OP_REMOVE, 32'd5);
    push_request(OP_LOOKUP, 32'd0);
    push_request(OP_INSERT, 32'd0);
    push_request(OP_REMOVE, 32'd0);
    push_request(OP_SPARE,  32'd0);
    push_request(OP_INSERT, 32'hFFFF_FFFF);
    push_request(OP_INSERT, 32'd1);
    push_request(OP_INSERT, 32'h8000_0000);
    push_request(OP_INSERT, 32'h7FFF_FFFF);
    push_request(OP_INSERT, 32'd1);
    push_request(OP_LOOKUP, 32'hFFFF_FFFF);
    push_request(OP_SPARE,  32'h8000_0000);
    push_request(OP_LOOKUP, 32'd2);
    push_request(OP_REMOVE, 32'd3);
    push_request(OP_REMOVE, 32'h8000_0000);
    push_request(OP_REMOVE, 32'd1);
    push_request(OP_INSERT, 32'h5555_5555);
    push_request(OP_INSERT, 32'hAAAA_AAAA);
    push_request(OP_LOOKUP, 32'h5555_5555);
    push_request(OP_REMOVE, 32'hFFFF_FFFF);
    push_request(OP_REMOVE, 32'h7FFF_FFFF);
    push_request(OP_REMOVE, 32'h5555_5555);
    push_request(OP_REMOVE, 32'hAAAA_AAAA);

    for (int phase = 0; phase < 3; phase++) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (answers_left != 0) @(negedge clk);
      snd_idle_pct <= (phase == 0) ? 26 : (phase == 1) ? 57 : 0;
      rcv_idle_pct <= (phase == 0) ? 57 : (phase == 1) ? 26 : 0;
      @(posedge clk);
      pool_cursor = 0;
      repeat (310) push_random(FILL_UP);
      pool_cursor = 0;
      repeat (230) push_random(DRAIN_DOWN);
      repeat (30) push_random(CHURN);
    end

    in_valid <= 1'b0;
    settle = 0;
    @(negedge clk);
    while (answers_left != 0 && settle < 4000) begin
      @(negedge clk);
      settle++;
    end
    repeat (16) @(posedge clk);

    $display("%0d requests sent, %0d answers checked, %0d inserts refused on a full store",
             requests_sent, answers_checked, full_refusals);
    $display("store filled and drained three times under three sender and receiver stall mixes");
    if (fail_count == 0 && answers_left == 0) begin
      $display("Test completed successfully");
    end else begin
      if (answers_left != 0) $display("%0t: %0d answers never arrived", $time, answers_left);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/skst_pkg.sv
hw/rtl/skst_dp.sv
hw/rtl/skst_ctrl.sv
hw/rtl/sorted_key_set_table.sv
sim/skst_result_checker.sv
sim/tb.sv
